// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the idle/standby power controller, all sampled
// on clk_i and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ISPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define ISPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ispc_pkg.sv -----
// ----------------------------------------------------------------------------
// ispc_pkg
// Shared types of the idle/standby power controller: modes, actions,
// operations, configuration, state, request and result records.
// ----------------------------------------------------------------------------
package ispc_pkg;

  typedef enum logic [1:0] {
    MODE_ON       = 2'd0,
    MODE_DIM      = 2'd1,
    MODE_STANDBY  = 2'd2,
    MODE_WIFI_OFF = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DIM     = 2'd1,
    ACT_OFF     = 2'd2,
    ACT_RESTORE = 2'd3
  } action_e;

  // code 3 is not a member and is ignored
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_TOUCH_WAKE = 2'd1,
    OP_PROX_WAKE  = 2'd2
  } op_e;

  typedef struct packed {
    logic [15:0] dim_delay;
    logic [15:0] standby_delay;
    logic [15:0] wifi_off_delay;
    logic [15:0] shutdown_delay;
    logic [15:0] log_period;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] idle;
    logic [15:0] log_cnt;
    logic [31:0] on_sec;
    logic [31:0] off_sec;
    logic        prox_on;
    logic        wifi_on;
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] average_power;
    logic        charging;
  } item_t;

  typedef struct packed {
    mode_e       power_mode;
    action_e     brightness_action;
    logic        proximity_enable;
    logic        wifi_enable;
    logic        shutdown_request;
    logic        battery_sample;
    logic [31:0] screen_on_seconds;
    logic [31:0] screen_off_seconds;
  } result_t;

endpackage

// ----- hdl/ispc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ispc_cfg_regs
// APB register file holding the delay and battery log period settings.
// ----------------------------------------------------------------------------
module ispc_cfg_regs import ispc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  typedef enum logic [2:0] {
    REG_DIM_DELAY      = 3'd0,
    REG_STANDBY_DELAY  = 3'd1,
    REG_WIFI_OFF_DELAY = 3'd2,
    REG_SHUTDOWN_DELAY = 3'd3,
    REG_LOG_PERIOD     = 3'd4
  } reg_idx_e;

  cfg_t        cfg_q;
  reg_idx_e    idx;
  logic        wr_en;
  logic [15:0] rd_val;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_delay      <= 16'd20;
      cfg_q.standby_delay  <= 16'd30;
      cfg_q.wifi_off_delay <= 16'd0;
      cfg_q.shutdown_delay <= 16'd0;
      cfg_q.log_period     <= 16'd60;
    end else if (wr_en) begin
      unique case (idx)
        REG_DIM_DELAY:      cfg_q.dim_delay      <= pwdata[15:0];
        REG_STANDBY_DELAY:  cfg_q.standby_delay  <= pwdata[15:0];
        REG_WIFI_OFF_DELAY: cfg_q.wifi_off_delay <= pwdata[15:0];
        REG_SHUTDOWN_DELAY: cfg_q.shutdown_delay <= pwdata[15:0];
        REG_LOG_PERIOD:     cfg_q.log_period     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIM_DELAY:      rd_val = cfg_q.dim_delay;
      REG_STANDBY_DELAY:  rd_val = cfg_q.standby_delay;
      REG_WIFI_OFF_DELAY: rd_val = cfg_q.wifi_off_delay;
      REG_SHUTDOWN_DELAY: rd_val = cfg_q.shutdown_delay;
      REG_LOG_PERIOD:     rd_val = cfg_q.log_period;
      default:            rd_val = 16'd0;
    endcase
  end

  assign prdata = {16'd0, rd_val};
  assign cfg_o  = cfg_q;

endmodule

// ----- hdl/ispc_step.sv -----
// ----------------------------------------------------------------------------
// ispc_step
// Next-state and result logic for one request: tick bookkeeping, timed
// mode moves and wake handling.
// ----------------------------------------------------------------------------
module ispc_step import ispc_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  op_e         op;
  logic        pwr_neg;
  logic        pwr_nonpos;
  state_t      st;
  action_e     act;
  logic        shut;
  logic        sample;
  logic [15:0] lc_inc;

  assign op         = op_e'(item_i.operation);
  assign pwr_neg    = item_i.average_power[15];
  assign pwr_nonpos = pwr_neg | (item_i.average_power == 16'd0);

  always_comb begin
    st     = state_i;
    act    = ACT_NONE;
    shut   = 1'b0;
    sample = 1'b0;
    lc_inc = state_i.log_cnt;
    case (op) inside
      OP_TICK: begin
        st.idle = sat_inc(state_i.idle);
        if (state_i.log_cnt != '1) begin
          lc_inc = state_i.log_cnt + 16'd1;
        end
        if (lc_inc == cfg_i.log_period) begin
          st.log_cnt = '0;
          sample     = 1'b1;
        end else begin
          st.log_cnt = lc_inc;
        end
        if (state_i.mode == MODE_ON || state_i.mode == MODE_DIM) begin
          st.on_sec = sat_inc(state_i.on_sec);
        end else begin
          st.off_sec = sat_inc(state_i.off_sec);
        end
        // moves cascade in order within one tick
        if (st.idle == {16'd0, cfg_i.dim_delay} && st.mode == MODE_ON) begin
          act     = ACT_DIM;
          st.mode = MODE_DIM;
        end
        if (st.idle == {16'd0, cfg_i.standby_delay} && st.mode == MODE_DIM) begin
          st.prox_on = 1'b1;
          act        = ACT_OFF;
          st.mode    = MODE_STANDBY;
        end
        if (st.idle == {16'd0, cfg_i.wifi_off_delay} && cfg_i.wifi_off_delay != 16'd0 &&
            st.mode == MODE_STANDBY && pwr_nonpos) begin
          st.wifi_on = 1'b0;
          st.mode    = MODE_WIFI_OFF;
        end
        if (st.idle == {16'd0, cfg_i.shutdown_delay} && cfg_i.shutdown_delay != 16'd0 &&
            (st.mode == MODE_STANDBY || st.mode == MODE_WIFI_OFF) &&
            pwr_neg && !item_i.charging) begin
          shut = 1'b1;
        end
      end
      OP_TOUCH_WAKE, OP_PROX_WAKE: begin
        if (state_i.mode != MODE_ON) begin
          if (state_i.mode == MODE_WIFI_OFF) begin
            st.wifi_on = 1'b1;
          end
          act     = ACT_RESTORE;
          st.mode = MODE_ON;
        end
        st.idle = '0;
        if (op == OP_TOUCH_WAKE) begin
          st.prox_on = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign state_o = st;

  assign result_o.power_mode         = st.mode;
  assign result_o.brightness_action  = act;
  assign result_o.proximity_enable   = st.prox_on;
  assign result_o.wifi_enable        = st.wifi_on;
  assign result_o.shutdown_request   = shut;
  assign result_o.battery_sample     = sample;
  assign result_o.screen_on_seconds  = st.on_sec;
  assign result_o.screen_off_seconds = st.off_sec;

endmodule

// ----- hdl/idle_standby_power_controller_unit.sv -----
// ----------------------------------------------------------------------------
// idle_standby_power_controller_unit
// Idle-timeout power mode controller (on, dim, standby, wifi off) with
// battery log sampling and screen on/off time accounting.
// ----------------------------------------------------------------------------
// Each request is a one-second tick or a wake event. A tick ages the idle
// count, steps the battery log counter (battery_sample pulses at the period)
// and moves on -> dim -> standby -> wifi off when the idle count equals the
// programmed delays (wifi off only at non-positive power); a shutdown_request
// pulse is raised in standby or wifi off on a discharging, non-charging
// battery at the shutdown delay. Wakes return to on and clear the idle count.
// Every request yields exactly one result. Throughput is one request per
// clock while the result side is not stalled: a request is captured in the
// input register, and the whole step runs as combinational logic from that
// register into the result register and the controller state. While a
// finished result waits to be taken the input register can still take one
// more request. Registers (APB, byte address 4*i): dim_delay, standby_delay,
// wifi_off_delay, shutdown_delay, battery_log_period; write them only while
// no request is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idle_standby_power_controller_unit import ispc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] average_power_i,
  input  logic               charging_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         power_mode_o,
  output logic [1:0]         brightness_action_o,
  output logic               proximity_enable_o,
  output logic               wifi_enable_o,
  output logic               shutdown_request_o,
  output logic               battery_sample_o,
  output logic [31:0]        screen_on_seconds_o,
  output logic [31:0]        screen_off_seconds_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    advance;

  // configuration registers
  ispc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // request moves from the input register into the result register
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  // input register: control with reset, payload without
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.operation     <= operation_i;
      in_q.average_power <= average_power_i;
      in_q.charging      <= charging_i;
    end
  end

  // combinational step logic
  ispc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // controller state commits when the request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_ON;
      state_q.idle    <= '0;
      state_q.log_cnt <= '0;
      state_q.on_sec  <= '0;
      state_q.off_sec <= '0;
      state_q.prox_on <= 1'b0;
      state_q.wifi_on <= 1'b1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign power_mode_o         = res_q.power_mode;
  assign brightness_action_o  = res_q.brightness_action;
  assign proximity_enable_o   = res_q.proximity_enable;
  assign wifi_enable_o        = res_q.wifi_enable;
  assign shutdown_request_o   = res_q.shutdown_request;
  assign battery_sample_o     = res_q.battery_sample;
  assign screen_on_seconds_o  = res_q.screen_on_seconds;
  assign screen_off_seconds_o = res_q.screen_off_seconds;

  // wifi is only ever off in the wifi-off mode
  `ISPC_ASSERT(a_wifi_off_mode,
    state_q.wifi_on || state_q.mode == MODE_WIFI_OFF,
    "wifi off outside wifi-off mode")

  // standby and wifi-off always keep proximity detection on
  `ISPC_ASSERT(a_prox_in_standby,
    !(state_q.mode == MODE_STANDBY || state_q.mode == MODE_WIFI_OFF) || state_q.prox_on,
    "proximity off in standby")

  // a shutdown pulse only comes from standby or wifi-off
  `ISPC_ASSERT(a_shut_mode,
    !(out_valid_q && res_q.shutdown_request) ||
      res_q.power_mode == MODE_STANDBY || res_q.power_mode == MODE_WIFI_OFF,
    "shutdown outside standby")

  // a restore result always lands in the on mode
  `ISPC_ASSERT(a_restore_on,
    !(out_valid_q && res_q.brightness_action == ACT_RESTORE) || res_q.power_mode == MODE_ON,
    "restore without on mode")

  // a committed wake clears the idle count
  `ISPC_ASSERT_NEXT(a_wake_clears_idle,
    advance && (in_q.operation == OP_TOUCH_WAKE || in_q.operation == OP_PROX_WAKE),
    state_q.idle == '0,
    "wake did not clear idle count")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the idle/standby power controller: a queue of
// ticks and wake requests feeds a valid/ready driver, an in-bench model of
// the mode, counter and pulse rules predicts each result, and a monitor
// compares every field while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import ispc_pkg::*;

  // register indexes, byte address is 4 times the index
  localparam int REG_DIM_DELAY     = 0;
  localparam int REG_STANDBY_DELAY = 1;
  localparam int REG_WIFI_DELAY    = 2;
  localparam int REG_SHUTDOWN      = 3;
  localparam int REG_LOG_PERIOD    = 4;

  // operation code outside op_e, must be ignored by the block
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_TICK;
  logic [15:0] average_power_i = '0;
  logic        charging_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  power_mode_o;
  logic [1:0]  brightness_action_o;
  logic        proximity_enable_o;
  logic        wifi_enable_o;
  logic        shutdown_request_o;
  logic        battery_sample_o;
  logic [31:0] screen_on_seconds_o;
  logic [31:0] screen_off_seconds_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // requests still to be offered and results still owed by the block
  item_t   request_q[$];
  result_t status_q[$];

  // idling percentages of sender and receiver
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 83;

  // one long receiver hold-off, counted down in the monitor
  bit hold_request = 1'b0;
  bit hold_taken   = 1'b0;
  int hold_left    = 0;

  int mismatches   = 0;
  int quiet_cycles = 0;
  int item_count   = 0;

  // in-bench copy of the programmed delays and the controller state
  cfg_t        cfg;
  mode_e       cur_mode;
  logic [31:0] idle_secs;
  logic [15:0] log_cnt;
  logic [31:0] on_secs;
  logic [31:0] off_secs;
  logic        prox_on;
  logic        wifi_on;

  idle_standby_power_controller_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .operation_i          (operation_i),
    .average_power_i      (average_power_i),
    .charging_i           (charging_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .power_mode_o         (power_mode_o),
    .brightness_action_o  (brightness_action_o),
    .proximity_enable_o   (proximity_enable_o),
    .wifi_enable_o        (wifi_enable_o),
    .shutdown_request_o   (shutdown_request_o),
    .battery_sample_o     (battery_sample_o),
    .screen_on_seconds_o  (screen_on_seconds_o),
    .screen_off_seconds_o (screen_off_seconds_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one step of the controller: updates the bench state, returns the result
  function automatic result_t apply_request(input item_t req);
    result_t          res;
    action_e          act;
    logic             shut;
    logic             sample;
    logic signed [15:0] pwr;
    act    = ACT_NONE;
    shut   = 1'b0;
    sample = 1'b0;
    pwr    = $signed(req.average_power);
    if (req.operation == OP_TICK) begin
      // counters stick at their top value
      if (idle_secs != 32'hFFFF_FFFF) idle_secs = idle_secs + 32'd1;
      if (log_cnt != 16'hFFFF) log_cnt = log_cnt + 16'd1;
      if (log_cnt == cfg.log_period) begin
        log_cnt = '0;
        sample  = 1'b1;
      end
      if (cur_mode == MODE_ON || cur_mode == MODE_DIM) begin
        if (on_secs != 32'hFFFF_FFFF) on_secs = on_secs + 32'd1;
      end else if (off_secs != 32'hFFFF_FFFF) begin
        off_secs = off_secs + 32'd1;
      end
      // moves in fixed order, so equal delays cascade within one tick
      if (idle_secs == {16'h0, cfg.dim_delay} && cur_mode == MODE_ON) begin
        act      = ACT_DIM;
        cur_mode = MODE_DIM;
      end
      if (idle_secs == {16'h0, cfg.standby_delay} && cur_mode == MODE_DIM) begin
        prox_on  = 1'b1;
        act      = ACT_OFF;
        cur_mode = MODE_STANDBY;
      end
      if (idle_secs == {16'h0, cfg.wifi_off_delay} && cfg.wifi_off_delay != 0 &&
          cur_mode == MODE_STANDBY && pwr <= 0) begin
        wifi_on  = 1'b0;
        cur_mode = MODE_WIFI_OFF;
      end
      if (idle_secs == {16'h0, cfg.shutdown_delay} && cfg.shutdown_delay != 0 &&
          (cur_mode == MODE_STANDBY || cur_mode == MODE_WIFI_OFF) &&
          pwr < 0 && !req.charging) begin
        shut = 1'b1;
      end
    end else if (req.operation == OP_TOUCH_WAKE || req.operation == OP_PROX_WAKE) begin
      if (cur_mode != MODE_ON) begin
        if (cur_mode == MODE_WIFI_OFF) wifi_on = 1'b1;
        act      = ACT_RESTORE;
        cur_mode = MODE_ON;
      end
      idle_secs = '0;
      if (req.operation == OP_TOUCH_WAKE) prox_on = 1'b0;
    end
    res.power_mode         = cur_mode;
    res.brightness_action  = act;
    res.proximity_enable   = prox_on;
    res.wifi_enable        = wifi_on;
    res.shutdown_request   = shut;
    res.battery_sample     = sample;
    res.screen_on_seconds  = on_secs;
    res.screen_off_seconds = off_secs;
    return res;
  endfunction

  // power values lean on the sign boundaries
  function automatic logic [15:0] rand_power();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_request(input logic [1:0] op, input logic [15:0] pwr,
                             input logic chg);
    item_t req;
    req.operation     = op;
    req.average_power = pwr;
    req.charging      = chg;
    request_q.push_back(req);
    if (op != OP_IGNORED) item_count++;
  endtask

  // apb write, setup then access phase
  task automatic write_reg(input int idx, input logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DIM_DELAY:     cfg.dim_delay      = val;
      REG_STANDBY_DELAY: cfg.standby_delay  = val;
      REG_WIFI_DELAY:    cfg.wifi_off_delay = val;
      REG_SHUTDOWN:      cfg.shutdown_delay = val;
      REG_LOG_PERIOD:    cfg.log_period     = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] dim, input logic [15:0] stby,
                           input logic [15:0] wifi, input logic [15:0] shut,
                           input logic [15:0] period);
    write_reg(REG_DIM_DELAY, dim);
    write_reg(REG_STANDBY_DELAY, stby);
    write_reg(REG_WIFI_DELAY, wifi);
    write_reg(REG_SHUTDOWN, shut);
    write_reg(REG_LOG_PERIOD, period);
  endtask

  // block is idle once every offered request has come back
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || status_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // random setting, then well-formed idle runs each closed by a wake
  task automatic run_segment(input bit with_hold);
    logic [15:0] dim, stby, wifi, shut, period;
    int          ticks;
    int          pick;
    dim  = 16'($urandom_range(1, 6));
    stby = dim + 16'($urandom_range(0, 3));
    wifi = stby + 16'($urandom_range(0, 3));
    shut = stby + 16'($urandom_range(0, 4));
    case ($urandom_range(7))
      0: dim = '0;
      1: wifi = '0;
      2: shut = '0;
      3: dim = 16'hFFFF;
      4: begin
        stby = dim;
        wifi = dim;
        shut = dim;
      end
      default: ;
    endcase
    case ($urandom_range(9))
      0:       period = '0;
      1:       period = 16'hFFFF;
      default: period = 16'($urandom_range(1, 9));
    endcase
    write_all(dim, stby, wifi, shut, period);
    for (int b = 0; b < 5; b++) begin
      ticks = $urandom_range(0, 18);
      for (int t = 0; t < ticks; t++)
        add_request(OP_TICK, rand_power(), 1'($urandom_range(1)));
      pick = $urandom_range(9);
      // noise: ignored codes and stray wakes
      if (pick == 0) add_request(OP_IGNORED, rand_power(), 1'($urandom_range(1)));
      if (pick == 1) add_request(OP_PROX_WAKE, rand_power(), 1'($urandom_range(1)));
      add_request(pick < 5 ? OP_TOUCH_WAKE : OP_PROX_WAKE, rand_power(),
                  1'($urandom_range(1)));
    end
    if (with_hold) begin
      @(negedge clk_i);
      hold_request = 1'b1;
    end
    wait_drained();
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_requests
    item_t cur;
    item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      cur.operation     = operation_i;
      cur.average_power = average_power_i;
      cur.charging      = charging_i;
      if (in_valid_i && in_ready_o) status_q.push_back(apply_request(cur));
      // a new request only once the held one is gone
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          operation_i     <= nxt.operation;
          average_power_i <= nxt.average_power;
          charging_i      <= nxt.charging;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk_i) begin : take_results
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding");
        end else begin
          want = status_q.pop_front();
          check_field("power_mode", 32'(want.power_mode), 32'(power_mode_o));
          check_field("brightness_action", 32'(want.brightness_action),
                      32'(brightness_action_o));
          check_field("proximity_enable", 32'(want.proximity_enable),
                      32'(proximity_enable_o));
          check_field("wifi_enable", 32'(want.wifi_enable), 32'(wifi_enable_o));
          check_field("shutdown_request", 32'(want.shutdown_request),
                      32'(shutdown_request_o));
          check_field("battery_sample", 32'(want.battery_sample),
                      32'(battery_sample_o));
          check_field("screen_on_seconds", want.screen_on_seconds, screen_on_seconds_o);
          check_field("screen_off_seconds", want.screen_off_seconds, screen_off_seconds_o);
        end
      end
      // long hold-off so the input side backs up
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // reset values of the registers and the state
    cfg.dim_delay      = 16'd20;
    cfg.standby_delay  = 16'd30;
    cfg.wifi_off_delay = 16'd0;
    cfg.shutdown_delay = 16'd0;
    cfg.log_period     = 16'd60;
    cur_mode  = MODE_ON;
    idle_secs = '0;
    log_cnt   = '0;
    on_secs   = '0;
    off_secs  = '0;
    prox_on   = 1'b0;
    wifi_on   = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short delays so every move shows up within a few ticks
    write_all(16'd2, 16'd3, 16'd4, 16'd5, 16'd3);
    add_request(OP_TOUCH_WAKE, 16'h7FFF, 1'b1);   // wake while on
    add_request(OP_PROX_WAKE, 16'h0001, 1'b0);
    add_request(OP_IGNORED, 16'h8000, 1'b1);      // ignored code
    add_request(OP_TICK, 16'h0000, 1'b0);
    add_request(OP_TICK, 16'hFFFF, 1'b0);         // dim
    add_request(OP_TICK, 16'h7FFF, 1'b1);         // standby, sample
    add_request(OP_TICK, 16'h0000, 1'b1);         // wifi off at zero power
    add_request(OP_TICK, 16'h8000, 1'b0);         // shutdown request
    add_request(OP_PROX_WAKE, 16'h5555, 1'b1);    // restore, proximity kept
    add_request(OP_TOUCH_WAKE, 16'hAAAA, 1'b0);   // on already, proximity cleared
    add_request(OP_TICK, 16'h0000, 1'b0);
    add_request(OP_TICK, 16'h0000, 1'b0);
    add_request(OP_TICK, 16'h0000, 1'b0);
    add_request(OP_TICK, 16'h0001, 1'b0);         // positive power keeps wifi
    add_request(OP_TICK, 16'hFFFF, 1'b1);         // charging blocks shutdown
    add_request(OP_TOUCH_WAKE, 16'h0000, 1'b0);
    wait_drained();

    // equal delays cascade in one tick, no battery sampling
    write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
    add_request(OP_TICK, 16'hFFFF, 1'b0);
    add_request(OP_TICK, 16'hFFFF, 1'b0);
    add_request(OP_TOUCH_WAKE, 16'h1234, 1'b1);
    wait_drained();

    // zero dim delay never fires
    write_all(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1);
    add_request(OP_TICK, 16'h8001, 1'b0);
    add_request(OP_TICK, 16'h7FFE, 1'b1);
    add_request(OP_PROX_WAKE, 16'h0000, 1'b0);
    wait_drained();

    // random: slow sender, very slow receiver, one long hold-off
    run_segment(1'b1);
    while (item_count < 140) run_segment(1'b0);

    // random: the other way round
    send_idle_pct = 83;
    recv_idle_pct = 18;
    while (item_count < 270) run_segment(1'b0);

    // random: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (item_count < 400) run_segment(1'b0);

    // log counter keeps climbing once the period is lowered below it
    write_all(16'd3, 16'd5, 16'd7, 16'd9, 16'hFFFF);
    for (int t = 0; t < 100; t++) add_request(OP_TICK, rand_power(), 1'($urandom_range(1)));
    wait_drained();
    write_reg(REG_LOG_PERIOD, 16'd50);
    for (int t = 0; t < 40; t++) add_request(OP_TICK, rand_power(), 1'b0);
    wait_drained();
    write_reg(REG_LOG_PERIOD, 16'hFFFF);
    for (int t = 0; t < 3; t++) add_request(OP_TICK, 16'h8000, 1'b0);
    add_request(OP_TOUCH_WAKE, 16'h0000, 1'b0);
    wait_drained();

    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ispc_pkg.sv
hdl/ispc_cfg_regs.sv
hdl/ispc_step.sv
hdl/idle_standby_power_controller_unit.sv
tb/tb.sv
